// File: src/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared widths, beat types and register codes of the disparity to point
// reprojection core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  // Field widths.
  localparam int COORD_BITS = 12;
  localparam int DISP_W     = 16;
  localparam int GRAY_W     = 8;
  localparam int CAM_W      = 16;
  localparam int BASE_W     = 18;
  localparam int POINT_W    = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Datapath widths: column*16 minus a center, times the baseline.
  localparam int SCALED_W = COORD_BITS + 4;
  localparam int DIFF_W   = ((SCALED_W > CAM_W) ? SCALED_W : CAM_W) + 1;
  localparam int PROD_W   = DIFF_W + BASE_W + 1;
  localparam int NUM_W    = DIFF_W - 1 + BASE_W;
  localparam int DEN_W    = DISP_W;
  localparam int REM_W    = DEN_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL   = 3'd0,
    REG_CCOL    = 3'd1,
    REG_CROW    = 3'd2,
    REG_BASE    = 3'd3,
    REG_INVALID = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   column;
    logic [COORD_BITS-1:0]   row;
    logic signed [DISP_W-1:0] disparity;
    logic [GRAY_W-1:0]       intensity;
  } in_beat_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;
    logic [COORD_BITS-1:0]     out_column;
    logic [COORD_BITS-1:0]     out_row;
    logic signed [DISP_W-1:0]  out_disparity;
    logic [GRAY_W-1:0]         out_intensity;
    logic                      point_valid;
  } out_beat_t;

endpackage

`default_nettype wire

// File: src/disparity_to_point_reprojection_core.sv
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_core
// Turns one disparity pixel per clock, while the output is not stalled, into a saturated Q16.16 3D point.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_data; a beat is taken when in_valid is high
//   and in_stall is low. Points leave on out_valid/out_data; the receiver
//   holds out_stall high to keep the current beat in place.
//   Camera registers are written on cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Write them only while no pixel is in flight.
// Pipeline, from input beat to output beat: one input register, difference,
//   multiply, magnitude, one restoring divider stage per quotient bit, then
//   sign and saturation.
// Throughput: one pixel per clock while the output is not stalled. The three
//   pipelined dividers, one per axis, set the depth.
// Reset: synchronous, active low; empties the pipeline, clears the camera
//   registers and sets the invalid disparity code to -16.
// Stall: the whole pipeline holds while the output beat is stalled, and
//   in_stall follows, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire dtp_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output dtp_pkg::out_beat_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtp_pkg::*;

  // Side data that travels beside the arithmetic.
  typedef struct packed {
    in_beat_t         pix;
    logic             ok;
    logic [2:0]       neg;
    logic [DEN_W-1:0] den;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } lane_t;

  typedef struct packed {
    side_t      sd;
    lane_t [2:0] ln;
  } div_t;

  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(33'h07FFFFFFF);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(33'h080000000);

  // Configuration registers.
  logic [CAM_W-1:0]         focal_r, ccol_r, crow_r;
  logic [BASE_W-1:0]        base_r;
  logic signed [DISP_W-1:0] invalid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r   <= '0;
      ccol_r    <= '0;
      crow_r    <= '0;
      base_r    <= '0;
      invalid_r <= -DISP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL:   focal_r   <= cfg_data[CAM_W-1:0];
        REG_CCOL:    ccol_r    <= cfg_data[CAM_W-1:0];
        REG_CROW:    crow_r    <= cfg_data[CAM_W-1:0];
        REG_BASE:    base_r    <= cfg_data[BASE_W-1:0];
        REG_INVALID: invalid_r <= cfg_data[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output beat can leave.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 0: input register.
  logic     v0_r;
  in_beat_t p0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= in_data;
    end
  end

  // Stage 1: centered coordinates, validity and divisor magnitude.
  logic                     v1_r;
  in_beat_t                 p1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r;
  logic                     ok1_r, dneg1_r;
  logic [DEN_W-1:0]         den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= p0_r;
      dx1_r   <= $signed(DIFF_W'({p0_r.column, 4'b0000})) - $signed(DIFF_W'(ccol_r));
      dy1_r   <= $signed(DIFF_W'({p0_r.row, 4'b0000})) - $signed(DIFF_W'(crow_r));
      ok1_r   <= (p0_r.disparity != '0) && (p0_r.disparity != invalid_r);
      dneg1_r <= p0_r.disparity[DISP_W-1];
      den1_r  <= p0_r.disparity[DISP_W-1] ? DEN_W'(-p0_r.disparity)
                                          : DEN_W'(p0_r.disparity);
    end
  end

  // Stage 2: products with the baseline.
  logic                     v2_r;
  side_t                    s2_r;
  logic signed [PROD_W-1:0] px2_r, py2_r;
  logic [NUM_W-1:0]         pz2_r;
  logic                     dneg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.pix <= p1_r;
      s2_r.ok  <= ok1_r;
      s2_r.neg <= '0;
      s2_r.den <= den1_r;
      dneg2_r  <= dneg1_r;
      px2_r    <= PROD_W'(dx1_r * $signed({1'b0, base_r}));
      py2_r    <= PROD_W'(dy1_r * $signed({1'b0, base_r}));
      pz2_r    <= NUM_W'(focal_r * base_r);
    end
  end

  // Stage 3: numerator magnitudes and result signs; loads the divider.
  logic       dvv_r [0:NUM_W];
  div_t       dv_r  [0:NUM_W];
  logic [2:0] neg3;
  side_t      sd3;

  assign neg3 = {dneg2_r, py2_r[PROD_W-1] ^ dneg2_r, px2_r[PROD_W-1] ^ dneg2_r};

  // Side data with the result signs filled in.
  always_comb begin
    sd3     = s2_r;
    sd3.neg = neg3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else if (adv) begin
      dvv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].sd       <= sd3;
      dv_r[0].ln[0].rem <= '0;
      dv_r[0].ln[1].rem <= '0;
      dv_r[0].ln[2].rem <= '0;
      dv_r[0].ln[0].nq <= px2_r[PROD_W-1] ? NUM_W'(-px2_r) : NUM_W'(px2_r);
      dv_r[0].ln[1].nq <= py2_r[PROD_W-1] ? NUM_W'(-py2_r) : NUM_W'(py2_r);
      dv_r[0].ln[2].nq <= pz2_r;
    end
  end

  // One restoring step: bring in the next numerator bit, subtract if it fits.
  function automatic lane_t div_step(lane_t a, logic [DEN_W-1:0] den);
    logic [REM_W:0] t;
    lane_t          r;
    t = {a.rem, a.nq[NUM_W-1]};
    if (t >= {2'b00, den}) begin
      r.rem = REM_W'(t - {2'b00, den});
      r.nq  = {a.nq[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = t[REM_W-1:0];
      r.nq  = {a.nq[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Divider stages, one quotient bit each, three axes side by side.
  for (genvar k = 1; k <= NUM_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k] <= 1'b0;
      end else if (adv) begin
        dvv_r[k] <= dvv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k].sd    <= dv_r[k-1].sd;
        dv_r[k].ln[0] <= div_step(dv_r[k-1].ln[0], dv_r[k-1].sd.den);
        dv_r[k].ln[1] <= div_step(dv_r[k-1].ln[1], dv_r[k-1].sd.den);
        dv_r[k].ln[2] <= div_step(dv_r[k-1].ln[2], dv_r[k-1].sd.den);
      end
    end
  end

  // Apply sign and saturate a quotient magnitude.
  function automatic logic [POINT_W-1:0] sat_q(logic [NUM_W-1:0] q, logic neg);
    logic [POINT_W-1:0] r;
    if (neg) begin
      r = (q > NEG_MAX) ? POINT_W'(NEG_MAX) : POINT_W'(-q);
    end else begin
      r = (q > POS_MAX) ? POINT_W'(POS_MAX) : POINT_W'(q);
    end
    return r;
  endfunction

  // Output register.
  div_t      last;
  out_beat_t out_nxt;
  out_beat_t out_r;
  logic      out_valid_r;

  assign last = dv_r[NUM_W];

  always_comb begin
    out_nxt.point_x       = last.sd.ok ? sat_q(last.ln[0].nq, last.sd.neg[0]) : '0;
    out_nxt.point_y       = last.sd.ok ? sat_q(last.ln[1].nq, last.sd.neg[1]) : '0;
    out_nxt.point_z       = last.sd.ok ? sat_q(last.ln[2].nq, last.sd.neg[2]) : '0;
    out_nxt.out_column    = last.sd.pix.column;
    out_nxt.out_row       = last.sd.pix.row;
    out_nxt.out_disparity = last.sd.pix.disparity;
    out_nxt.out_intensity = last.sd.pix.intensity;
    out_nxt.point_valid   = last.sd.ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dvv_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/dtp_checker.sv
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks of the reprojection core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dtp_pkg::out_beat_t out_data,
  input wire logic               cfg_ready
);
  import dtp_pkg::*;

  // A stalled output beat stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Input backpressure comes only from a stalled output beat.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // An invalid point carries zero coordinates.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |->
      out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("invalid point has nonzero coordinates");

  // Zero disparity is never reported as a valid point.
  a_zero_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_disparity == '0 |-> !out_data.point_valid)
    else $error("zero disparity marked valid");

  // The configuration port never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind disparity_to_point_reprojection_core dtp_checker u_dtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

// File: test/tb_disparity_to_point_reprojection_core.sv
// ----------------------------------------------------------------------------
// tb_disparity_to_point_reprojection_core
// Drives pixels through the reprojection core under several camera settings,
// with random gaps and output stalls, and checks every output beat against
// a point predictor with its own copy of the camera registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_disparity_to_point_reprojection_core;
  import dtp_pkg::*;

  // Predicts the point of each pixel and checks output beats in order.
  class point_scoreboard;
    logic [CAM_W-1:0]  focal;
    logic [CAM_W-1:0]  ccol;
    logic [CAM_W-1:0]  crow;
    logic [BASE_W-1:0] base;
    logic signed [DISP_W-1:0] invalid_code;
    out_beat_t pending_points[$];
    int errors;

    function void reset_regs();
      focal = '0;
      ccol = '0;
      crow = '0;
      base = '0;
      invalid_code = -16'sd16;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FOCAL:   focal = val[CAM_W-1:0];
        REG_CCOL:    ccol = val[CAM_W-1:0];
        REG_CROW:    crow = val[CAM_W-1:0];
        REG_BASE:    base = val[BASE_W-1:0];
        REG_INVALID: invalid_code = val[DISP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] sat_quot(longint num, longint den);
      longint q;
      q = num / den;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function void note_pixel(in_beat_t px);
      out_beat_t r;
      longint d;
      d = px.disparity;
      r = '0;
      r.out_column = px.column;
      r.out_row = px.row;
      r.out_disparity = px.disparity;
      r.out_intensity = px.intensity;
      r.point_valid = (px.disparity != 0) && (px.disparity != invalid_code);
      if (r.point_valid) begin
        r.point_x = sat_quot((longint'({px.column, 4'b0}) - longint'(ccol)) * longint'(base), d);
        r.point_y = sat_quot((longint'({px.row, 4'b0}) - longint'(crow)) * longint'(base), d);
        r.point_z = sat_quot(longint'(focal) * longint'(base), d);
      end
      pending_points.insert(pending_points.size(), r);
    endfunction

    function void check_point(out_beat_t got);
      out_beat_t exp_pt;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, got);
        errors++;
        return;
      end
      exp_pt = pending_points.pop_front();
      if (got.point_x !== exp_pt.point_x)
        $display("%0t: point_x exp %0d got %0d", $realtime, exp_pt.point_x, got.point_x);
      if (got.point_y !== exp_pt.point_y)
        $display("%0t: point_y exp %0d got %0d", $realtime, exp_pt.point_y, got.point_y);
      if (got.point_z !== exp_pt.point_z)
        $display("%0t: point_z exp %0d got %0d", $realtime, exp_pt.point_z, got.point_z);
      if (got.out_column !== exp_pt.out_column)
        $display("%0t: column exp %0d got %0d", $realtime, exp_pt.out_column, got.out_column);
      if (got.out_row !== exp_pt.out_row)
        $display("%0t: row exp %0d got %0d", $realtime, exp_pt.out_row, got.out_row);
      if (got.out_disparity !== exp_pt.out_disparity)
        $display("%0t: disparity exp %0d got %0d", $realtime, exp_pt.out_disparity,
                 got.out_disparity);
      if (got.out_intensity !== exp_pt.out_intensity)
        $display("%0t: intensity exp %0d got %0d", $realtime, exp_pt.out_intensity,
                 got.out_intensity);
      if (got.point_valid !== exp_pt.point_valid)
        $display("%0t: valid exp %0b got %0b", $realtime, exp_pt.point_valid, got.point_valid);
      if (got !== exp_pt) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  point_scoreboard sb;
  bit stall_enable;

  disparity_to_point_reprojection_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Check each accepted output beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_point(out_data);
  end

  // Receiver stalls, driven at the falling edge.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = stall_enable ? gap_len() : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Writes one register; the caller drops cfg_valid after its last write.
  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Sends one pixel beat, with an optional gap before it.
  task automatic send_pixel(in_beat_t px, bit with_gap);
    int n;
    n = with_gap ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // Lets the pipeline empty before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  function in_beat_t rand_pixel(logic signed [DISP_W-1:0] code);
    in_beat_t px;
    int k;
    px.column = COORD_BITS'($urandom);
    px.row = COORD_BITS'($urandom);
    px.intensity = GRAY_W'($urandom);
    k = $urandom_range(0, 9);
    case (k)
      0: px.disparity = '0;
      1: px.disparity = code;
      2: px.disparity = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: px.disparity = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      4, 5: px.disparity = DISP_W'($urandom);
      default: px.disparity = DISP_W'($urandom_range(16, 2048));
    endcase
    return px;
  endfunction

  task automatic set_camera(int f, int cc, int cr, int b, int code);
    write_cfg(REG_FOCAL, CFG_DATA_W'(f));
    write_cfg(REG_CCOL, CFG_DATA_W'(cc));
    write_cfg(REG_CROW, CFG_DATA_W'(cr));
    write_cfg(REG_BASE, CFG_DATA_W'(b));
    write_cfg(REG_INVALID, CFG_DATA_W'(code));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_beat_t px;
    sb = new();
    sb.reset_regs();
    stall_enable = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: base is zero, so valid points are all zero.
    px = '{12'd5, 12'd7, 16'sd32, 8'd9};
    send_pixel(px, 0);
    px.disparity = -16'sd16;
    send_pixel(px, 0);
    drain();

    // Directed pixels at a typical camera, then at the extremes.
    set_camera(16'd11200, 16'd5120, 16'd3840, 18'd7864, 16'hfff0);
    send_pixel('{12'd0, 12'd0, 16'sd256, 8'd0}, 0);
    send_pixel('{12'hfff, 12'hfff, 16'sd256, 8'hff}, 0);
    send_pixel('{12'd320, 12'd240, 16'sd0, 8'd1}, 0);
    send_pixel('{12'd320, 12'd240, -16'sd16, 8'd2}, 0);
    send_pixel('{12'd100, 12'd50, -16'sd300, 8'd3}, 0);
    send_pixel('{12'd100, 12'd50, 16'sh7fff, 8'd4}, 0);
    send_pixel('{12'd100, 12'd50, 16'sh8000, 8'd5}, 0);
    send_pixel('{12'd100, 12'd50, 16'sd1, 8'd6}, 0);
    send_pixel('{12'hfff, 12'd0, -16'sd1, 8'd7}, 0);
    send_pixel('{12'haaa, 12'h555, 16'sd17, 8'haa}, 0);
    send_pixel('{12'h555, 12'haaa, 16'sd33, 8'h55}, 0);
    drain();
    set_camera(16'hffff, 16'hffff, 16'hffff, 18'h3ffff, 16'h8000);
    send_pixel('{12'd0, 12'hfff, 16'sd1, 8'd0}, 0);
    send_pixel('{12'hfff, 12'd0, -16'sd1, 8'd1}, 0);
    send_pixel('{12'd3, 12'd3, 16'sh8000, 8'd2}, 0);
    send_pixel('{12'd3, 12'd3, 16'sh7fff, 8'd3}, 0);
    send_pixel('{12'd3, 12'd3, -16'sd16, 8'd4}, 0);
    drain();
    // Excess high bits of a 16-bit register are dropped.
    set_camera(18'h30000, 18'h20000, 18'h10000, 18'd0, 18'h37fff);
    send_pixel('{12'd9, 12'd9, 16'sh7fff, 8'd1}, 0);
    send_pixel('{12'd9, 12'd9, 16'sd64, 8'd2}, 0);
    drain();

    // Random phases, each with its own camera setting.
    stall_enable = 1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_camera(16'd8000, 16'd10240, 16'd7680, 18'd13107, 16'hfff0);
        1: set_camera(16'hffff, 16'd0, 16'hffff, 18'h3ffff, 16'h7fff);
        default: set_camera($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 262143),
                            $urandom_range(0, 65535));
      endcase
      for (int i = 0; i < 270; i++) begin
        send_pixel(rand_pixel(sb.invalid_code), 1);
        // Hold the sender until the pipeline has emptied.
        if (i == 135) begin
          in_valid <= 1'b0;
          while (sb.pending_points.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
